/* hw/rtl/srvb_pkg.sv */
// ----------------------------------------------------------------------------
// srvb_pkg
// Shared widths, register codes, reset values and fixed-point helpers for the
// four-comb, two-allpass reverberator.
// ----------------------------------------------------------------------------
`default_nettype none

package srvb_pkg;

  // Delay line geometry and data widths.
  localparam int LINE_DEPTH = 2048;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int SAMPLE_W   = 16;
  localparam int STORE_W    = SAMPLE_W + 8;
  localparam int WIDE_W     = STORE_W + 2;
  localparam int GAIN_W     = 16;
  localparam int PROD_W     = STORE_W + GAIN_W + 1;
  localparam int LEN_W      = 11;
  localparam int NUM_COMB   = 4;
  localparam int NUM_AP     = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Output queue and outstanding-item count.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECAY_GAIN       = 3'd0,
    REG_COMB_LENGTH_A    = 3'd1,
    REG_COMB_LENGTH_B    = 3'd2,
    REG_COMB_LENGTH_C    = 3'd3,
    REG_COMB_LENGTH_D    = 3'd4,
    REG_ALLPASS_LENGTH_A = 3'd5,
    REG_ALLPASS_LENGTH_B = 3'd6
  } cfg_reg_t;

  // Reset values of the registers.
  localparam logic [GAIN_W-1:0] DECAY_GAIN_RST       = 16'd55706;
  localparam logic [LEN_W-1:0]  COMB_LENGTH_A_RST    = 11'd1557;
  localparam logic [LEN_W-1:0]  COMB_LENGTH_B_RST    = 11'd1617;
  localparam logic [LEN_W-1:0]  COMB_LENGTH_C_RST    = 11'd1491;
  localparam logic [LEN_W-1:0]  COMB_LENGTH_D_RST    = 11'd1422;
  localparam logic [LEN_W-1:0]  ALLPASS_LENGTH_A_RST = 11'd225;
  localparam logic [LEN_W-1:0]  ALLPASS_LENGTH_B_RST = 11'd556;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [STORE_W-1:0]  store_t;
  typedef logic signed [WIDE_W-1:0]   wide_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [LEN_W-1:0]           len_t;

  // Sign-extend a stored value to the working width.
  function automatic wide_t widen(input store_t v);
    return {{(WIDE_W-STORE_W){v[STORE_W-1]}}, v};
  endfunction

  // Sign-extend a sample to the working width.
  function automatic wide_t widen_sample(input sample_t v);
    return {{(WIDE_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

  // Clamp a working value to the stored width.
  function automatic store_t sat_store(input wide_t v);
    store_t res;
    if (v[WIDE_W-1:STORE_W-1] == {(WIDE_W-STORE_W+1){1'b0}} ||
        v[WIDE_W-1:STORE_W-1] == {(WIDE_W-STORE_W+1){1'b1}}) begin
      res = v[STORE_W-1:0];
    end else if (v[WIDE_W-1]) begin
      res = {1'b1, {(STORE_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(STORE_W-1){1'b1}}};
    end
    return res;
  endfunction

  // Clamp a stored value to the sample width.
  function automatic sample_t sat_sample(input store_t v);
    sample_t res;
    if (v[STORE_W-1:SAMPLE_W-1] == {(STORE_W-SAMPLE_W+1){1'b0}} ||
        v[STORE_W-1:SAMPLE_W-1] == {(STORE_W-SAMPLE_W+1){1'b1}}) begin
      res = v[SAMPLE_W-1:0];
    end else if (v[STORE_W-1]) begin
      res = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return res;
  endfunction

  // Half of v, rounded to nearest with ties toward plus infinity.
  function automatic wide_t half_up(input store_t v);
    wide_t n;
    n = widen(v) + wide_t'(1);
    return {n[WIDE_W-1], n[WIDE_W-1:1]};
  endfunction

  // Half of -v, rounded the same way.
  function automatic wide_t half_neg(input store_t v);
    wide_t n;
    n = wide_t'(1) - widen(v);
    return {n[WIDE_W-1], n[WIDE_W-1:1]};
  endfunction

  // Entry read by a line of the given length at the given write position.
  function automatic addr_t read_addr(input addr_t pos, input len_t len);
    return pos - addr_t'(len);
  endfunction

  // An entry holds written data once the position has passed it or wrapped.
  function automatic logic entry_written(input addr_t r, input addr_t pos,
                                         input logic wrapped);
    return wrapped || (r < pos);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/schroeder_reverb_top.sv */
// ----------------------------------------------------------------------------
// schroeder_reverb_top
// Four feedback comb lines in parallel, averaged, then two allpass stages in
// series. Each delay line is a 2048 x 24 synchronous RAM with registered read.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                          Direction  Item
//   in       in_valid, in_stall, sample_in    sink       dry Q1.15 sample
//   out      out_valid, out_stall, sample_out source     wet Q1.15 sample
//   cfg      cfg_write, cfg_index, cfg_data   sink       register write
//
// An item is never taken in the cycle after an acceptance: that cycle is held
// so that the comb write of one item lands on the edge where the next reads.
// Reset needs no clearing pass: a wrap flag and the write position tell which
// entries were ever written, and unwritten entries read as zero.
// A 4-entry output queue lets the pipeline run while out_stall is high;
// in_stall rises once 4 items are outstanding.
//
`default_nettype none

module schroeder_reverb_top (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [srvb_pkg::SAMPLE_W-1:0]   sample_in,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [srvb_pkg::SAMPLE_W-1:0]   sample_out,
  input  wire                             cfg_write,
  input  wire  [srvb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [srvb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import srvb_pkg::*;

  // Configuration registers.
  logic [GAIN_W-1:0] decay_gain;
  len_t              comb_len [NUM_COMB];
  len_t              ap_len   [NUM_AP];

  // Write position and wrap flag.
  addr_t wp;
  logic  wrapped;

  // Handshakes.
  logic accept;
  logic pop;
  logic push;

  // Stage 1: comb reads returned.
  logic    s1_valid;
  sample_t s1_x;
  addr_t   s1_pos;
  logic    s1_wrapped;
  store_t  comb_rd  [NUM_COMB];
  logic    comb_ok  [NUM_COMB];
  addr_t   comb_raddr [NUM_COMB];
  store_t  comb_del [NUM_COMB];
  logic signed [PROD_W-1:0] comb_prod [NUM_COMB];
  wide_t   comb_sum;
  wide_t   mix_round;

  // Stage 2: comb write-back and first allpass.
  logic    s2_valid;
  sample_t s2_x;
  addr_t   s2_pos;
  logic    s2_wrapped;
  logic signed [PROD_W-1:0] s2_prod [NUM_COMB];
  store_t  s2_mix;
  store_t  comb_wdata [NUM_COMB];
  addr_t   apa_raddr;
  store_t  apa_rd;
  logic    apa_ok;
  store_t  apa_del;
  store_t  apa_t;

  // Stage 3: first allpass output.
  logic    s3_valid;
  addr_t   s3_pos;
  logic    s3_wrapped;
  store_t  s3_t;
  store_t  s3_del;
  store_t  apa_out;

  // Stage 4: second allpass write-back.
  logic    s4_valid;
  addr_t   s4_pos;
  store_t  s4_s;
  addr_t   apb_raddr;
  store_t  apb_rd;
  logic    apb_ok;
  store_t  apb_del;
  store_t  apb_t;

  // Stage 5: second allpass output.
  logic    s5_valid;
  store_t  s5_t;
  store_t  s5_del;
  store_t  apb_out;

  // Output queue and outstanding count.
  sample_t                fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  fifo_wptr;
  logic [FIFO_PTR_W-1:0]  fifo_rptr;
  logic [OCC_W-1:0]       fifo_count;
  logic [OCC_W-1:0]       occ;

  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;
  assign push     = s5_valid;
  assign in_stall = s1_valid || (occ == OCC_W'(FIFO_DEPTH));

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      decay_gain  <= DECAY_GAIN_RST;
      comb_len[0] <= COMB_LENGTH_A_RST;
      comb_len[1] <= COMB_LENGTH_B_RST;
      comb_len[2] <= COMB_LENGTH_C_RST;
      comb_len[3] <= COMB_LENGTH_D_RST;
      ap_len[0]   <= ALLPASS_LENGTH_A_RST;
      ap_len[1]   <= ALLPASS_LENGTH_B_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_DECAY_GAIN:       decay_gain  <= cfg_data[GAIN_W-1:0];
        REG_COMB_LENGTH_A:    comb_len[0] <= cfg_data[LEN_W-1:0];
        REG_COMB_LENGTH_B:    comb_len[1] <= cfg_data[LEN_W-1:0];
        REG_COMB_LENGTH_C:    comb_len[2] <= cfg_data[LEN_W-1:0];
        REG_COMB_LENGTH_D:    comb_len[3] <= cfg_data[LEN_W-1:0];
        REG_ALLPASS_LENGTH_A: ap_len[0]   <= cfg_data[LEN_W-1:0];
        REG_ALLPASS_LENGTH_B: ap_len[1]   <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Write position advances once per item; the wrap flag marks a full pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
    end else if (accept) begin
      wp <= wp + addr_t'(1);
      if (wp == addr_t'(LINE_DEPTH - 1)) begin
        wrapped <= 1'b1;
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x       <= sample_t'(sample_in);
      s1_pos     <= wp;
      s1_wrapped <= wrapped;
      for (int i = 0; i < NUM_COMB; i++) begin
        comb_ok[i] <= entry_written(comb_raddr[i], wp, wrapped);
      end
    end
    if (s1_valid) begin
      s2_x       <= s1_x;
      s2_pos     <= s1_pos;
      s2_wrapped <= s1_wrapped;
      s2_mix     <= mix_round[WIDE_W-1:2];
      apa_ok     <= entry_written(apa_raddr, s1_pos, s1_wrapped);
      for (int i = 0; i < NUM_COMB; i++) begin
        s2_prod[i] <= comb_prod[i];
      end
    end
    if (s2_valid) begin
      s3_pos     <= s2_pos;
      s3_wrapped <= s2_wrapped;
      s3_t       <= apa_t;
      s3_del     <= apa_del;
    end
    if (s3_valid) begin
      s4_pos <= s3_pos;
      s4_s   <= apa_out;
      apb_ok <= entry_written(apb_raddr, s3_pos, s3_wrapped);
    end
    if (s4_valid) begin
      s5_t   <= apb_t;
      s5_del <= apb_del;
    end
  end

  // Comb read addresses for the item being accepted.
  always_comb begin
    for (int i = 0; i < NUM_COMB; i++) begin
      comb_raddr[i] = read_addr(wp, comb_len[i]);
    end
  end

  // Comb line RAMs: the write of the previous item, held in stage 2, is forwarded
  // when it hits the entry being read on the same edge.
  for (genvar g = 0; g < NUM_COMB; g++) begin : g_comb
    store_t mem [LINE_DEPTH];

    always_ff @(posedge clk) begin
      if (s2_valid) begin
        mem[s2_pos] <= comb_wdata[g];
      end
      if (accept) begin
        if (s2_valid && (s2_pos == comb_raddr[g])) begin
          comb_rd[g] <= comb_wdata[g];
        end else begin
          comb_rd[g] <= mem[comb_raddr[g]];
        end
      end
    end
  end

  // Stage 1: feedback products and the quarter-scaled mix of the four taps.
  always_comb begin
    comb_sum = '0;
    for (int i = 0; i < NUM_COMB; i++) begin
      comb_del[i]  = comb_ok[i] ? comb_rd[i] : '0;
      comb_prod[i] = comb_del[i] * $signed({1'b0, decay_gain});
      comb_sum     = comb_sum + widen(comb_del[i]);
    end
    mix_round = comb_sum + wide_t'(2);
  end

  // Stage 2: comb write data, input plus rounded feedback.
  always_comb begin
    logic signed [PROD_W-1:0] p;
    wide_t                    fb;
    for (int i = 0; i < NUM_COMB; i++) begin
      p             = s2_prod[i] + PROD_W'(1 << (GAIN_W - 1));
      fb            = {p[PROD_W-1], p[PROD_W-1:GAIN_W]};
      comb_wdata[i] = sat_store(widen_sample(s2_x) + fb);
    end
  end

  // First allpass RAM: read while the mix is formed, write in the following cycle.
  assign apa_raddr = read_addr(s1_pos, ap_len[0]);

  always_ff @(posedge clk) begin : p_apa_ram
    store_t mem [LINE_DEPTH];
    if (s2_valid) begin
      mem[s2_pos] <= apa_t;
    end
    if (s1_valid) begin
      apa_rd <= mem[apa_raddr];
    end
  end

  // Stage 2: first allpass feed-forward value.
  assign apa_del = apa_ok ? apa_rd : '0;
  assign apa_t   = sat_store(widen(s2_mix) + half_neg(apa_del));

  // Stage 3: first allpass output.
  assign apa_out = sat_store(widen(s3_del) + half_up(s3_t));

  // Second allpass RAM.
  assign apb_raddr = read_addr(s3_pos, ap_len[1]);

  always_ff @(posedge clk) begin : p_apb_ram
    store_t mem [LINE_DEPTH];
    if (s4_valid) begin
      mem[s4_pos] <= apb_t;
    end
    if (s3_valid) begin
      apb_rd <= mem[apb_raddr];
    end
  end

  // Stage 4: second allpass feed-forward value.
  assign apb_del = apb_ok ? apb_rd : '0;
  assign apb_t   = sat_store(widen(s4_s) + half_neg(apb_del));

  // Stage 5: second allpass output.
  assign apb_out = sat_store(widen(s5_del) + half_up(s5_t));

  // Output queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[fifo_wptr] <= sat_sample(apb_out);
    end
  end

  // Output queue pointers and the count of outstanding items.
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_wptr  <= '0;
      fifo_rptr  <= '0;
      fifo_count <= '0;
      occ        <= '0;
    end else begin
      if (push) begin
        fifo_wptr <= fifo_wptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        fifo_rptr <= fifo_rptr + FIFO_PTR_W'(1);
      end
      fifo_count <= fifo_count + OCC_W'(push) - OCC_W'(pop);
      occ        <= occ + OCC_W'(accept) - OCC_W'(pop);
    end
  end

  assign out_valid  = (fifo_count != '0);
  assign sample_out = fifo_mem[fifo_rptr];

endmodule

`default_nettype wire

/* hw/rtl/srvb_checker.sv */
// ----------------------------------------------------------------------------
// srvb_checker
// Port-level checks on the reverberator: item spacing, credit limit, no output
// without an outstanding item or after reset, and output hold under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module srvb_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           in_valid,
  input wire                           in_stall,
  input wire                           out_valid,
  input wire                           out_stall,
  input wire [srvb_pkg::SAMPLE_W-1:0]  sample_out
);
  import srvb_pkg::*;

  logic             in_acc;
  logic             out_acc;
  logic [OCC_W-1:0] pending;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Items taken but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + OCC_W'(in_acc) - OCC_W'(out_acc);
    end
  end

  // An accepted item blocks the input for the following cycle.
  a_spacing: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("input taken on two consecutive cycles");

  // The input holds off once the output queue could be full.
  a_credit: assert property (@(posedge clk) disable iff (rst)
    (pending == OCC_W'(FIFO_DEPTH)) |-> in_stall)
    else $error("input open with all queue entries claimed");

  // No result appears without an outstanding item.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != '0))
    else $error("result shown with no item outstanding");

  // Nothing is shown right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown after reset");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(sample_out)))
    else $error("stalled result changed");

endmodule

bind schroeder_reverb_top srvb_checker u_srvb_checker (.*);

`default_nettype wire
